[src/irn_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// irn_pkg
// shared constants and types of the nearest-neighbor image rotator
// ----------------------------------------------------------------------------
package irn_pkg;

  // store side and output grid sizes
  localparam int MAX_DIM = 256;
  localparam int OUT_DIM = 512;
  localparam int DIM_W   = $clog2(MAX_DIM);
  localparam int ADDR_W  = 2 * DIM_W;

  // field widths
  localparam int COORD_W = 9;
  localparam int COLOR_W = 8;
  localparam int PIX_W   = 3 * COLOR_W;
  localparam int TRIG_W  = 16;
  localparam int CFG_W   = 16;
  localparam int IDX_W   = 2;

  // doubled, centered coordinate and its products
  localparam int X2_W    = COORD_W + 2;
  localparam int PROD_W  = X2_W + TRIG_W;
  localparam int SUM_W   = PROD_W + 1;
  localparam int FRAC_W  = 15;
  localparam int Q_W     = SUM_W - FRAC_W;
  localparam int SRC_W   = Q_W + 1;

  // configuration register indexes
  localparam logic [IDX_W-1:0] CFG_SRC_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] CFG_SRC_HEIGHT = 2'd1;
  localparam logic [IDX_W-1:0] CFG_COS        = 2'd2;
  localparam logic [IDX_W-1:0] CFG_SIN        = 2'd3;

  // reset values
  localparam logic [COORD_W-1:0] RST_WIDTH  = 9'd256;
  localparam logic [COORD_W-1:0] RST_HEIGHT = 9'd256;
  localparam logic [TRIG_W-1:0]  RST_COS    = 16'd16384;
  localparam logic [TRIG_W-1:0]  RST_SIN    = 16'd0;

  // color of a point that maps outside the source
  localparam logic [COLOR_W-1:0] FILL_RG = 8'd0;
  localparam logic [COLOR_W-1:0] FILL_B  = 8'd255;

  typedef struct packed {
    logic [COORD_W-1:0] src_width;
    logic [COORD_W-1:0] src_height;
    logic [TRIG_W-1:0]  cos_q14;
    logic [TRIG_W-1:0]  sin_q14;
  } cfg_t;

  // request to the pixel store stage
  typedef struct packed {
    logic              valid;
    logic              fetch;
    logic              we;
    logic              outside;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  wdata;
  } mem_req_t;

endpackage

`default_nettype wire

[src/irn_map.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// irn_map
// three-stage inverse mapping of an output position into the source image
// ----------------------------------------------------------------------------
module irn_map (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire irn_pkg::cfg_t               cfg_i,
  input  wire logic                        valid_i,
  input  wire logic                        fetch_i,
  input  wire logic [irn_pkg::COORD_W-1:0] row_i,
  input  wire logic [irn_pkg::COORD_W-1:0] col_i,
  input  wire logic [irn_pkg::PIX_W-1:0]   pix_i,
  output irn_pkg::mem_req_t                req_o
);

  // stage b: products
  logic                        b_valid_q, b_fetch_q, b_grid_out_q, b_load_ok_q;
  logic [irn_pkg::ADDR_W-1:0]  b_laddr_q;
  logic [irn_pkg::PIX_W-1:0]   b_pix_q;
  logic signed [irn_pkg::PROD_W-1:0] b_xc_q, b_ys_q, b_xs_q, b_yc_q;
  logic signed [irn_pkg::PROD_W-1:0] b_xc_d, b_ys_d, b_xs_d, b_yc_d;
  logic signed [irn_pkg::X2_W-1:0]   x2, y2;

  // stage c: rotated and re-centered source point
  logic                        c_valid_q, c_fetch_q, c_grid_out_q, c_load_ok_q;
  logic [irn_pkg::ADDR_W-1:0]  c_laddr_q;
  logic [irn_pkg::PIX_W-1:0]   c_pix_q;
  logic signed [irn_pkg::SRC_W-1:0] c_sx_q, c_sy_q, c_sx_d, c_sy_d;
  logic signed [irn_pkg::SUM_W-1:0] sum_x, sum_y;
  logic signed [irn_pkg::Q_W-1:0]   qx, qy;

  // stage d: bounds check and store address
  irn_pkg::mem_req_t d_req_q, d_req_d;
  logic              sx_out, sy_out;

  always_comb begin
    x2 = $signed({1'b0, col_i, 1'b0}) - $signed({2'b0, cfg_i.src_width});
    y2 = $signed({1'b0, row_i, 1'b0}) - $signed({2'b0, cfg_i.src_height});
    b_xc_d = x2 * $signed(cfg_i.cos_q14);
    b_ys_d = y2 * $signed(cfg_i.sin_q14);
    b_xs_d = x2 * $signed(cfg_i.sin_q14);
    b_yc_d = y2 * $signed(cfg_i.cos_q14);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else begin
      b_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    b_fetch_q    <= fetch_i;
    b_grid_out_q <= (int'(row_i) >= irn_pkg::OUT_DIM) || (int'(col_i) >= irn_pkg::OUT_DIM);
    b_load_ok_q  <= (int'(row_i) < irn_pkg::MAX_DIM) && (int'(col_i) < irn_pkg::MAX_DIM);
    b_laddr_q    <= {row_i[irn_pkg::DIM_W-1:0], col_i[irn_pkg::DIM_W-1:0]};
    b_pix_q      <= pix_i;
    b_xc_q       <= b_xc_d;
    b_ys_q       <= b_ys_d;
    b_xs_q       <= b_xs_d;
    b_yc_q       <= b_yc_d;
  end

  // floor by 2^15 is the upper slice of the two's complement sum
  always_comb begin
    sum_x  = $signed({b_xc_q[irn_pkg::PROD_W-1], b_xc_q})
           - $signed({b_ys_q[irn_pkg::PROD_W-1], b_ys_q});
    sum_y  = $signed({b_xs_q[irn_pkg::PROD_W-1], b_xs_q})
           + $signed({b_yc_q[irn_pkg::PROD_W-1], b_yc_q});
    qx     = sum_x[irn_pkg::SUM_W-1:irn_pkg::FRAC_W];
    qy     = sum_y[irn_pkg::SUM_W-1:irn_pkg::FRAC_W];
    c_sx_d = $signed({qx[irn_pkg::Q_W-1], qx})
           + $signed({{(irn_pkg::SRC_W-irn_pkg::COORD_W+1){1'b0}},
                      cfg_i.src_width[irn_pkg::COORD_W-1:1]});
    c_sy_d = $signed({qy[irn_pkg::Q_W-1], qy})
           + $signed({{(irn_pkg::SRC_W-irn_pkg::COORD_W+1){1'b0}},
                      cfg_i.src_height[irn_pkg::COORD_W-1:1]});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else begin
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c_fetch_q    <= b_fetch_q;
    c_grid_out_q <= b_grid_out_q;
    c_load_ok_q  <= b_load_ok_q;
    c_laddr_q    <= b_laddr_q;
    c_pix_q      <= b_pix_q;
    c_sx_q       <= c_sx_d;
    c_sy_q       <= c_sy_d;
  end

  always_comb begin
    sx_out = c_sx_q[irn_pkg::SRC_W-1]
          || (c_sx_q >= $signed({{(irn_pkg::SRC_W-irn_pkg::COORD_W){1'b0}},
                                 cfg_i.src_width}))
          || (int'(c_sx_q) >= irn_pkg::MAX_DIM);
    sy_out = c_sy_q[irn_pkg::SRC_W-1]
          || (c_sy_q >= $signed({{(irn_pkg::SRC_W-irn_pkg::COORD_W){1'b0}},
                                 cfg_i.src_height}))
          || (int'(c_sy_q) >= irn_pkg::MAX_DIM);
    d_req_d.valid   = c_valid_q;
    d_req_d.fetch   = c_fetch_q;
    d_req_d.we      = c_valid_q && !c_fetch_q && c_load_ok_q;
    d_req_d.outside = c_grid_out_q || sx_out || sy_out;
    d_req_d.addr    = c_fetch_q ? {c_sy_q[irn_pkg::DIM_W-1:0], c_sx_q[irn_pkg::DIM_W-1:0]}
                                : c_laddr_q;
    d_req_d.wdata   = c_pix_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_req_q <= '0;
    end else begin
      d_req_q <= d_req_d;
    end
  end

  assign req_o = d_req_q;

endmodule

`default_nettype wire

[src/image_rotate_nearest.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// image_rotate_nearest
// rotates an rgb image by inverse mapping with nearest-neighbor sampling
// ----------------------------------------------------------------------------
// usage
//   a request is taken at each rising edge with start_i high and busy_o low;
//   busy_o never rises, so a request can be issued every cycle
//   operation_i low: load request, writes red/green/blue into the pixel
//   store at (row_i, col_i); a position beyond the store is dropped and a
//   load gives no result
//   operation_i high: fetch request, maps output (row_i, col_i) back into
//   the source with the configured cosine and sine and returns the pixel,
//   or blue with outside_o set when the point is off the source image
//   results show on the output ports for one cycle with done_o high;
//   the receiver cannot stall, so nothing is held back
//   a fetch is presented after the input, product, rotation, bounds and
//   read registers; one request per cycle, set by the single store port
//   loads and fetches reach the store in request order, so a fetch sees
//   every load issued before it
//   configuration writes (cfg_we_i) take effect at once; they are to be made
//   while no request is in flight, which the block itself does not enforce
//   reset clears the pipeline valid bits and restores 256x256, no rotation;
//   the pixel store is not cleared and holds garbage until loaded
// ----------------------------------------------------------------------------
module image_rotate_nearest (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // request channel
  input  wire logic                          start_i,
  output      logic                          busy_o,
  input  wire logic                          operation_i,
  input  wire logic [irn_pkg::COORD_W-1:0]   row_i,
  input  wire logic [irn_pkg::COORD_W-1:0]   col_i,
  input  wire logic [irn_pkg::COLOR_W-1:0]   red_in_i,
  input  wire logic [irn_pkg::COLOR_W-1:0]   green_in_i,
  input  wire logic [irn_pkg::COLOR_W-1:0]   blue_in_i,
  // configuration write port
  input  wire logic                          cfg_we_i,
  input  wire logic [irn_pkg::IDX_W-1:0]     cfg_index_i,
  input  wire logic [irn_pkg::CFG_W-1:0]     cfg_data_i,
  // result channel
  output      logic                          done_o,
  output      logic [irn_pkg::COLOR_W-1:0]   red_out_o,
  output      logic [irn_pkg::COLOR_W-1:0]   green_out_o,
  output      logic [irn_pkg::COLOR_W-1:0]   blue_out_o,
  output      logic                          outside_o
);

  // configuration registers
  irn_pkg::cfg_t cfg_q;

  // input register stage
  logic                         a_valid_q;
  logic                         a_fetch_q;
  logic [irn_pkg::COORD_W-1:0]  a_row_q, a_col_q;
  logic [irn_pkg::PIX_W-1:0]    a_pix_q;

  // request into the store stage
  irn_pkg::mem_req_t            req;

  // store stage
  logic [irn_pkg::PIX_W-1:0]    store_q [2**irn_pkg::ADDR_W];
  logic [irn_pkg::PIX_W-1:0]    rdata_q;
  logic                         e_valid_q;
  logic                         e_outside_q;

  // the pipeline never stalls
  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.src_width  <= irn_pkg::RST_WIDTH;
      cfg_q.src_height <= irn_pkg::RST_HEIGHT;
      cfg_q.cos_q14    <= irn_pkg::RST_COS;
      cfg_q.sin_q14    <= irn_pkg::RST_SIN;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        irn_pkg::CFG_SRC_WIDTH:  cfg_q.src_width  <= cfg_data_i[irn_pkg::COORD_W-1:0];
        irn_pkg::CFG_SRC_HEIGHT: cfg_q.src_height <= cfg_data_i[irn_pkg::COORD_W-1:0];
        irn_pkg::CFG_COS:        cfg_q.cos_q14    <= cfg_data_i[irn_pkg::TRIG_W-1:0];
        irn_pkg::CFG_SIN:        cfg_q.sin_q14    <= cfg_data_i[irn_pkg::TRIG_W-1:0];
        default: ;
      endcase
    end
  end

  // capture each accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    a_fetch_q <= operation_i;
    a_row_q   <= row_i;
    a_col_q   <= col_i;
    a_pix_q   <= {red_in_i, green_in_i, blue_in_i};
  end

  // products, rotation and bounds check over three stages
  irn_map u_map (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (a_valid_q),
    .fetch_i (a_fetch_q),
    .row_i   (a_row_q),
    .col_i   (a_col_q),
    .pix_i   (a_pix_q),
    .req_o   (req)
  );

  // single-port store: loads and fetches use it in the same stage, so
  // request order is kept without any forwarding
  always_ff @(posedge clk_i) begin
    if (req.we) begin
      store_q[req.addr] <= req.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q     <= store_q[req.addr];
    e_outside_q <= req.outside;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q <= 1'b0;
    end else begin
      e_valid_q <= req.valid && req.fetch;
    end
  end

  // outside points read as blue
  assign done_o      = e_valid_q;
  assign outside_o   = e_outside_q;
  assign red_out_o   = e_outside_q ? irn_pkg::FILL_RG
                                   : rdata_q[3*irn_pkg::COLOR_W-1:2*irn_pkg::COLOR_W];
  assign green_out_o = e_outside_q ? irn_pkg::FILL_RG
                                   : rdata_q[2*irn_pkg::COLOR_W-1:irn_pkg::COLOR_W];
  assign blue_out_o  = e_outside_q ? irn_pkg::FILL_B
                                   : rdata_q[irn_pkg::COLOR_W-1:0];

endmodule

`default_nettype wire
